[rtl/color_gradient_interpolator_assert.svh]
// ----------------------------------------------------------------------------
// color gradient interpolator assertion macros
// shared property forms for the gradient block
// ----------------------------------------------------------------------------
`ifndef COLOR_GRADIENT_INTERPOLATOR_ASSERT_SVH
`define COLOR_GRADIENT_INTERPOLATOR_ASSERT_SVH

// same-cycle implication
`define CGI_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gradient assertion failed");

// next-cycle implication
`define CGI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gradient assertion failed");

`endif

[rtl/cgi_pkg.sv]
// ----------------------------------------------------------------------------
// cgi_pkg
// types and constants shared by the gradient interpolator files
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cgi_pkg;

    localparam int POS_W   = 16;
    localparam int COLOR_W = 32;
    localparam int CH_W    = 8;
    localparam int SLOT_W  = 3;
    localparam int COUNT_W = 4;

    typedef logic [POS_W-1:0]   t_pos;
    typedef logic [COLOR_W-1:0] t_color;
    typedef logic [CH_W-1:0]    t_chan;
    typedef logic [SLOT_W-1:0]  t_slot;
    typedef logic [COUNT_W-1:0] t_count;

    typedef struct packed {
        t_pos   pos;
        t_color color;
    } t_stop;

    localparam logic   KIND_WRITE = 1'b0;
    localparam logic   KIND_EVAL  = 1'b1;
    localparam t_color C_BLACK    = 32'hFF00_0000;

endpackage

[rtl/cgi_in_if.sv]
// ----------------------------------------------------------------------------
// cgi_in_if
// input channel: stop writes and evaluate requests
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cgi_in_if;
    logic            valid;
    logic            ready;
    logic            kind;
    cgi_pkg::t_slot  stop_index;
    cgi_pkg::t_pos   position;
    cgi_pkg::t_color stop_color;

    modport source (output valid, kind, stop_index, position, stop_color, input ready);
    modport sink   (input valid, kind, stop_index, position, stop_color, output ready);
endinterface

[rtl/cgi_out_if.sv]
// ----------------------------------------------------------------------------
// cgi_out_if
// output channel: interpolated argb color
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cgi_out_if;
    logic           valid;
    logic           ready;
    cgi_pkg::t_chan alpha;
    cgi_pkg::t_chan red;
    cgi_pkg::t_chan green;
    cgi_pkg::t_chan blue;

    modport source (output valid, alpha, red, green, blue, input ready);
    modport sink   (input valid, alpha, red, green, blue, output ready);
endinterface

[rtl/color_gradient_interpolator.sv]
// interpolated evaluate: o_word.valid follows the stop memory scan (one slot per cycle),
// the divider (one weight bit per cycle) and one shared multiplier (a product step, then
// an accumulate step, per channel); one word at a time
// end-stop evaluate and empty table skip the divider and the blend; a stop write is taken while idle
// reset: synchronous active low, stop_count clears to 0, stop memory is not cleared
// ----------------------------------------------------------------------------
// color_gradient_interpolator
// multi-stop argb gradient lookup with sequential scan, divide and blend
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "color_gradient_interpolator_assert.svh"

module color_gradient_interpolator #(
    parameter int MAX_STOPS   = 8,
    parameter int WEIGHT_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  cgi_pkg::t_count   i_cfg_data,
    cgi_in_if.sink            i_item,
    cgi_out_if.source         o_word
);
    import cgi_pkg::*;

    localparam int AW = $clog2(MAX_STOPS);
    localparam int CW = $clog2(MAX_STOPS + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_BLEND = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0]    r_state, n_state;
    t_count        r_count;
    logic [CW-1:0] r_n, n_n;
    logic [AW-1:0] r_idx, n_idx;
    t_pos          r_pos, n_pos;
    t_stop         r_prev, n_prev;
    t_color        r_left, n_left;
    t_color        r_right, n_right;
    t_color        r_res, n_res;
    logic          r_out_valid, n_out_valid;
    t_color        r_out_col, n_out_col;

    logic          w_accept;
    logic          w_we;
    logic [AW-1:0] w_raddr;
    logic          w_re;
    t_stop         w_rd;
    logic          w_le;
    logic          w_last;
    logic          w_div_start;
    logic          w_div_done;
    logic [WEIGHT_BITS:0] w_weight;
    logic          w_blend_start;
    logic          w_blend_done;
    t_color        w_blend_col;
    logic [CW-1:0] w_cnt_cap;
    logic          w_out_load;

    assign i_item.ready = (r_state == S_IDLE);
    assign w_accept     = i_item.valid && i_item.ready;
    assign w_we         = w_accept && i_item.kind == KIND_WRITE
                          && int'(i_item.stop_index) < MAX_STOPS;

    cgi_ram #(
        .WIDTH ($bits(t_stop)),
        .DEPTH (MAX_STOPS)
    ) u_stops (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (AW'(i_item.stop_index)),
        .i_wdata ({i_item.position, i_item.stop_color}),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rd)
    );

    cgi_div #(
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_delta (r_pos - r_prev.pos),
        .i_dmax  (w_rd.pos - r_prev.pos),
        .o_done  (w_div_done),
        .o_quo   (w_weight)
    );

    assign w_blend_start = (r_state == S_DIV) && w_div_done;

    cgi_blend #(
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_blend (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_blend_start),
        .i_weight (w_weight),
        .i_left   (r_left),
        .i_right  (r_right),
        .o_done   (w_blend_done),
        .o_color  (w_blend_col)
    );

    always_comb begin
        w_cnt_cap = (int'(r_count) > MAX_STOPS) ? CW'(MAX_STOPS) : CW'(r_count);
        w_le      = r_pos <= w_rd.pos;
        w_last    = (CW'(r_idx) + CW'(1)) == r_n;
    end

    always_comb begin
        n_state     = r_state;
        n_n         = r_n;
        n_idx       = r_idx;
        n_pos       = r_pos;
        n_prev      = r_prev;
        n_left      = r_left;
        n_right     = r_right;
        n_res       = r_res;
        n_out_valid = r_out_valid && !o_word.ready;
        n_out_col   = r_out_col;
        w_re        = 1'b0;
        w_raddr     = r_idx;
        w_div_start = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept && i_item.kind == KIND_EVAL) begin
                    n_pos = i_item.position;
                    n_n   = w_cnt_cap;
                    if (w_cnt_cap == '0) begin
                        n_res   = C_BLACK;
                        n_state = S_OUT;
                    end else begin
                        w_re    = 1'b1;
                        w_raddr = '0;
                        n_idx   = '0;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (w_le && r_idx != '0) begin
                    w_div_start = 1'b1;
                    n_left      = r_prev.color;
                    n_right     = w_rd.color;
                    n_state     = S_DIV;
                end else if (w_le || w_last) begin
                    n_res   = w_rd.color;
                    n_state = S_OUT;
                end else begin
                    n_prev  = w_rd;
                    w_re    = 1'b1;
                    w_raddr = r_idx + AW'(1);
                    n_idx   = r_idx + AW'(1);
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_state = S_BLEND;
                end
            end
            S_BLEND: begin
                if (w_blend_done) begin
                    n_res   = w_blend_col;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || o_word.ready) begin
                    n_out_valid = 1'b1;
                    n_out_col   = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_count <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_n       <= n_n;
        r_idx     <= n_idx;
        r_pos     <= n_pos;
        r_prev    <= n_prev;
        r_left    <= n_left;
        r_right   <= n_right;
        r_res     <= n_res;
        r_out_col <= n_out_col;
    end

    assign o_word.valid = r_out_valid;
    assign o_word.alpha = r_out_col[31:24];
    assign o_word.red   = r_out_col[23:16];
    assign o_word.green = r_out_col[15:8];
    assign o_word.blue  = r_out_col[7:0];

    assign w_out_load = (r_state == S_OUT) && (!r_out_valid || o_word.ready);

    `CGI_ASSERT_NOW(a_div_done_in_div, i_clk, i_rst_n, w_div_done, r_state == S_DIV)
    `CGI_ASSERT_NOW(a_blend_done_in_blend, i_clk, i_rst_n, w_blend_done, r_state == S_BLEND)
    `CGI_ASSERT_NOW(a_weight_nonzero, i_clk, i_rst_n, w_div_done, w_weight != '0)
    `CGI_ASSERT_NOW(a_scan_in_range, i_clk, i_rst_n, r_state == S_SCAN, CW'(r_idx) < r_n)
    `CGI_ASSERT_NEXT(a_out_load, i_clk, i_rst_n, w_out_load, r_out_valid && r_state == S_IDLE)

endmodule

[rtl/cgi_ram.sv]
// ----------------------------------------------------------------------------
// cgi_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cgi_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/cgi_div.sv]
// ----------------------------------------------------------------------------
// cgi_div
// restoring divider, one weight bit per cycle: (delta << wb) / dmax
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cgi_div #(
    parameter int WEIGHT_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  cgi_pkg::t_pos          i_delta,
    input  cgi_pkg::t_pos          i_dmax,
    output logic                   o_done,
    output logic [WEIGHT_BITS:0]   o_quo
);
    import cgi_pkg::*;

    localparam int STEPS = WEIGHT_BITS + 1;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic             r_busy;
    logic             r_done;
    logic             r_first;
    logic [CNT_W-1:0] r_cnt;
    t_pos             r_rem;
    t_pos             r_dmax;
    logic [WEIGHT_BITS:0] r_quo;

    logic [POS_W:0] w_cand;
    logic [POS_W:0] w_diff;
    logic           w_ge;

    always_comb begin
        w_cand = r_first ? {1'b0, r_rem} : {r_rem, 1'b0};
        w_ge   = w_cand >= {1'b0, r_dmax};
        w_diff = w_cand - {1'b0, r_dmax};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem   <= i_delta;
            r_dmax  <= i_dmax;
            r_first <= 1'b1;
            r_cnt   <= CNT_W'(STEPS);
        end else if (r_busy) begin
            r_rem   <= w_ge ? w_diff[POS_W-1:0] : w_cand[POS_W-1:0];
            r_quo   <= {r_quo[WEIGHT_BITS-1:0], w_ge};
            r_first <= 1'b0;
            r_cnt   <= r_cnt - CNT_W'(1);
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

[rtl/cgi_blend.sv]
// ----------------------------------------------------------------------------
// cgi_blend
// per-channel linear blend through one shared multiplier, alpha first
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cgi_blend #(
    parameter int WEIGHT_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [WEIGHT_BITS:0] i_weight,
    input  cgi_pkg::t_color      i_left,
    input  cgi_pkg::t_color      i_right,
    output logic                 o_done,
    output cgi_pkg::t_color      o_color
);
    import cgi_pkg::*;

    localparam int PW = WEIGHT_BITS + 11;
    localparam logic [PW-1:0] HALF = PW'(1) << (WEIGHT_BITS - 1);

    logic                 r_busy;
    logic                 r_done;
    logic                 r_phase;
    logic [1:0]           r_ch;
    logic [WEIGHT_BITS:0] r_w;
    t_color               r_left;
    t_color               r_right;
    logic signed [PW-1:0] r_prod;
    t_color               r_col;

    t_chan                       w_cl;
    t_chan                       w_cr;
    logic signed [CH_W:0]        w_diff;
    logic signed [WEIGHT_BITS+1:0] w_ws;
    logic signed [PW-1:0]        w_prod;
    logic [PW-1:0]               w_acc;

    always_comb begin
        case (r_ch)
            2'd0: begin
                w_cl = r_left[31:24];
                w_cr = r_right[31:24];
            end
            2'd1: begin
                w_cl = r_left[23:16];
                w_cr = r_right[23:16];
            end
            2'd2: begin
                w_cl = r_left[15:8];
                w_cr = r_right[15:8];
            end
            default: begin
                w_cl = r_left[7:0];
                w_cr = r_right[7:0];
            end
        endcase
        w_diff = $signed({1'b0, w_cr}) - $signed({1'b0, w_cl});
        w_ws   = $signed({1'b0, r_w});
        w_prod = w_diff * w_ws;
        w_acc  = {3'b000, w_cl, {WEIGHT_BITS{1'b0}}} + $unsigned(r_prod) + HALF;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_phase && r_ch == 2'd3) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_w     <= i_weight;
            r_left  <= i_left;
            r_right <= i_right;
            r_ch    <= 2'd0;
            r_phase <= 1'b0;
        end else if (r_busy) begin
            if (!r_phase) begin
                r_prod  <= w_prod;
                r_phase <= 1'b1;
            end else begin
                r_col   <= {r_col[COLOR_W-CH_W-1:0], w_acc[WEIGHT_BITS+CH_W-1:WEIGHT_BITS]};
                r_ch    <= r_ch + 2'd1;
                r_phase <= 1'b0;
            end
        end
    end

    assign o_done  = r_done;
    assign o_color = r_col;

endmodule

[sim/color_gradient_interpolator_test.sv]
// ----------------------------------------------------------------------------
// color_gradient_interpolator_test
// Self-checking bench for the gradient interpolator. A stimulus table first
// covers an empty table, colors at and beyond the end stops, exact stop hits,
// duplicate and unsorted positions and counts above the table size. Random
// phases then load sorted stop tables at fixed or random counts and evaluate positions
// against an in-bench color predictor, with random ready/valid idling, one
// long output hold-off, and a calm tail with no idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module color_gradient_interpolator_test;
    import cgi_pkg::*;

    localparam int STOP_SLOTS   = 8;
    localparam int WEIGHT_FRAC  = 16;
    localparam int NUM_PHASES   = 13;
    localparam int EVALS_PER_PH = 28;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 50;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int MAX_REPORTS  = 10;
    localparam logic [32:0] WEIGHT_ONE  = 33'h1_0000;
    localparam logic [32:0] WEIGHT_HALF = 33'h0_8000;

    typedef enum logic {ROW_COUNT, ROW_WORD} t_row_op;

    typedef struct packed {
        logic   kind;
        t_slot  slot;
        t_pos   pos;
        t_color color;
    } t_gradient_word;

    typedef struct packed {
        t_row_op        op;
        t_count         count;
        t_gradient_word word;
        bit             typed;
        t_color         want;
    } t_script_row;

    logic    i_clk = 1'b0;
    logic    i_rst_n;
    logic    i_cfg_we;
    t_count  i_cfg_data;

    cgi_in_if  item_bus ();
    cgi_out_if color_bus ();

    // predictor copy of the stop table and count
    t_pos   grad_pos [STOP_SLOTS];
    t_color grad_color [STOP_SLOTS];
    t_count grad_count;

    t_color      expected_colors [$];
    t_script_row script [$];

    int  mismatches;
    int  colors_checked;
    int  stop_writes;
    int  evaluates;
    int  count_settings;
    int  cycle_count;
    int  stall_left;
    bit  hold_request;
    bit  calm_tail;
    bit  gaps_on;

    color_gradient_interpolator #(
        .MAX_STOPS   (STOP_SLOTS),
        .WEIGHT_BITS (WEIGHT_FRAC)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_item     (item_bus),
        .o_word     (color_bus)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic t_color predict_color(input t_pos q);
        int          n;
        int          i;
        int          ch;
        logic [32:0] span;
        logic [32:0] offset;
        logic [32:0] weight;
        logic [31:0] acc;
        t_color      lc;
        t_color      rc;
        t_color      res;
        n = (grad_count > STOP_SLOTS) ? STOP_SLOTS : int'(grad_count);
        if (n == 0) begin
            return C_BLACK;
        end
        if (q <= grad_pos[0]) begin
            return grad_color[0];
        end
        for (i = 1; i < n; i++) begin
            if (q <= grad_pos[i]) begin
                span   = {17'd0, grad_pos[i]} - {17'd0, grad_pos[i-1]};
                offset = {17'd0, q} - {17'd0, grad_pos[i-1]};
                weight = (offset << WEIGHT_FRAC) / span;
                lc = grad_color[i-1];
                rc = grad_color[i];
                for (ch = 0; ch < 4; ch++) begin
                    acc = lc[ch*8 +: 8] * (WEIGHT_ONE - weight) + rc[ch*8 +: 8] * weight
                          + WEIGHT_HALF;
                    res[ch*8 +: 8] = acc[WEIGHT_FRAC +: 8];
                end
                return res;
            end
        end
        return grad_color[n-1];
    endfunction

    task automatic add_count(input t_count c);
        t_script_row row;
        row = '0;
        row.op = ROW_COUNT;
        row.count = c;
        script.insert(script.size(), row);
    endtask

    task automatic add_word(input logic kind, input t_slot slot, input t_pos pos,
                            input t_color color, input bit typed, input t_color want);
        t_script_row row;
        row = '0;
        row.op = ROW_WORD;
        row.word = '{kind: kind, slot: slot, pos: pos, color: color};
        row.typed = typed;
        row.want = want;
        script.insert(script.size(), row);
    endtask

    task automatic send_word(input t_gradient_word w, input bit typed, input t_color want);
        @(negedge i_clk);
        item_bus.valid      = 1'b1;
        item_bus.kind       = w.kind;
        item_bus.stop_index = w.slot;
        item_bus.position   = w.pos;
        item_bus.stop_color = w.color;
        @(posedge i_clk);
        while (!item_bus.ready) @(posedge i_clk);
        if (w.kind == KIND_WRITE) begin
            grad_pos[w.slot]   = w.pos;
            grad_color[w.slot] = w.color;
            stop_writes++;
        end else begin
            expected_colors.insert(expected_colors.size(),
                                   typed ? want : predict_color(w.pos));
            evaluates++;
        end
    endtask

    task automatic pace_sender();
        int k;
        if (!calm_tail && gaps_on && $urandom_range(0, 3) == 0) begin
            k = $urandom_range(1, 13);
            repeat (k) begin
                @(negedge i_clk);
                item_bus.valid = 1'b0;
            end
        end
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        item_bus.valid = 1'b0;
        while (expected_colors.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_count(input t_count c);
        wait_idle();
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_data = c;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        grad_count = c;
        count_settings++;
    endtask

    task automatic report_mismatch(input string what, input t_color want, input t_color got);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("mismatch %s: expected argb %02h %02h %02h %02h, got %02h %02h %02h %02h",
                     what, want[31:24], want[23:16], want[15:8], want[7:0],
                     got[31:24], got[23:16], got[15:8], got[7:0]);
        end
    endtask

    // output side: random ready bursts, one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            stall_left = HOLD_CYCLES;
        end
        if (stall_left > 0) begin
            color_bus.ready = 1'b0;
            stall_left--;
        end else if (calm_tail) begin
            color_bus.ready = 1'b1;
        end else if ($urandom_range(0, 5) == 0) begin
            color_bus.ready = 1'b0;
            stall_left = $urandom_range(1, 13) - 1;
        end else begin
            color_bus.ready = 1'b1;
        end
    end

    always @(posedge i_clk) begin : check_colors
        t_color seen;
        t_color want;
        if (i_rst_n && color_bus.valid && color_bus.ready) begin
            seen = {color_bus.alpha, color_bus.red, color_bus.green, color_bus.blue};
            colors_checked++;
            if (expected_colors.size() == 0) begin
                report_mismatch("unexpected word", '0, seen);
            end else begin
                want = expected_colors.pop_front();
                if (seen[31:24] != want[31:24] || seen[23:16] != want[23:16] ||
                    seen[15:8] != want[15:8] || seen[7:0] != want[7:0]) begin
                    report_mismatch("color", want, seen);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout, %0d colors still expected", expected_colors.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        t_gradient_word w;
        t_script_row    row;
        t_count         c;
        int             phase;
        int             e;
        int             s;
        int             n;
        int             pick;
        int             cursor;
        int             room;
        int             inc;

        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_data          = '0;
        item_bus.valid      = 1'b0;
        item_bus.kind       = KIND_WRITE;
        item_bus.stop_index = '0;
        item_bus.position   = '0;
        item_bus.stop_color = '0;
        color_bus.ready     = 1'b0;
        grad_count          = '0;
        hold_request        = 1'b0;
        calm_tail           = 1'b0;
        gaps_on             = 1'b1;
        stall_left          = 0;
        mismatches          = 0;
        colors_checked      = 0;
        stop_writes         = 0;
        evaluates           = 0;
        count_settings      = 0;
        cycle_count         = 0;

        // empty table after reset
        add_word(KIND_EVAL, 3'd0, 16'h0000, 32'h0, 1'b1, C_BLACK);
        add_word(KIND_EVAL, 3'd7, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, C_BLACK);
        // full table: duplicate position at slots 1/2, unsorted slot 5, top at 6/7
        add_word(KIND_WRITE, 3'd0, 16'h1000, 32'h0000_0000, 1'b0, '0);
        add_word(KIND_WRITE, 3'd1, 16'h2000, 32'hFFFF_FFFF, 1'b0, '0);
        add_word(KIND_WRITE, 3'd2, 16'h2000, 32'h8040_20FF, 1'b0, '0);
        add_word(KIND_WRITE, 3'd3, 16'h9000, 32'h0102_0304, 1'b0, '0);
        add_word(KIND_WRITE, 3'd4, 16'hA000, 32'hFFFF_FFFF, 1'b0, '0);
        add_word(KIND_WRITE, 3'd5, 16'h3000, 32'h55AA_55AA, 1'b0, '0);
        add_word(KIND_WRITE, 3'd6, 16'hFFFF, 32'h0000_0000, 1'b0, '0);
        add_word(KIND_WRITE, 3'd7, 16'hFFFF, 32'hDEAD_BEEF, 1'b0, '0);
        add_count(4'd1);
        add_word(KIND_EVAL, 3'd0, 16'h0000, 32'h0, 1'b1, 32'h0000_0000);
        add_word(KIND_EVAL, 3'd0, 16'hFFFF, 32'h0, 1'b1, 32'h0000_0000);
        add_count(4'd2);
        add_word(KIND_EVAL, 3'd0, 16'h1000, 32'h0, 1'b1, 32'h0000_0000);
        add_word(KIND_EVAL, 3'd0, 16'h1800, 32'h0, 1'b0, '0);
        add_word(KIND_EVAL, 3'd0, 16'h2000, 32'h0, 1'b1, 32'hFFFF_FFFF);
        add_word(KIND_EVAL, 3'd0, 16'hFFFF, 32'h0, 1'b1, 32'hFFFF_FFFF);
        add_word(KIND_EVAL, 3'd0, 16'h1001, 32'h0, 1'b0, '0);
        add_count(4'd8);
        add_word(KIND_EVAL, 3'd0, 16'h9800, 32'h0, 1'b0, '0);
        add_word(KIND_EVAL, 3'd0, 16'h2800, 32'h0, 1'b0, '0);
        add_word(KIND_EVAL, 3'd0, 16'hFFFF, 32'h0, 1'b0, '0);
        // count above table size
        add_count(4'd15);
        add_word(KIND_EVAL, 3'd0, 16'hFFFF, 32'h0, 1'b0, '0);
        add_word(KIND_EVAL, 3'd0, 16'h0000, 32'h0, 1'b1, 32'h0000_0000);
        add_word(KIND_EVAL, 3'd0, 16'h2000, 32'h0, 1'b0, '0);

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (script[r]) begin
            row = script[r];
            if (row.op == ROW_COUNT) begin
                apply_count(row.count);
            end else begin
                pace_sender();
                send_word(row.word, row.typed, row.want);
            end
        end

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                1: c = 4'd15;
                2: c = 4'd0;
                3: c = 4'd1;
                4: c = 4'd8;
                default: c = ($urandom_range(0, 3) == 0) ? t_count'($urandom_range(0, 15))
                                                        : t_count'($urandom_range(2, 8));
            endcase
            apply_count(c);
            calm_tail = (phase >= NUM_PHASES - 2);
            gaps_on = (phase % 4 != 1);
            if (phase == 4) begin
                hold_request = 1'b1;
            end
            n = (c > STOP_SLOTS) ? STOP_SLOTS : int'(c);

            // sorted stop table for the valid slots
            cursor = $urandom_range(0, 16'h3000);
            for (s = 0; s < n; s++) begin
                w.kind  = KIND_WRITE;
                w.slot  = t_slot'(s);
                w.pos   = t_pos'(cursor);
                w.color = $urandom;
                pace_sender();
                send_word(w, 1'b0, '0);
                room = 16'hFFFF - cursor;
                if ($urandom_range(0, 3) == 0) begin
                    inc = $urandom_range(0, 2);
                end else begin
                    inc = $urandom_range(0, room / (n - s));
                end
                cursor = cursor + ((inc > room) ? room : inc);
            end

            for (e = 0; e < EVALS_PER_PH; e++) begin
                w.slot  = t_slot'($urandom_range(0, 7));
                w.color = $urandom;
                if ($urandom_range(0, 19) < 3) begin
                    // stray stop write, may leave the table unsorted
                    w.kind = KIND_WRITE;
                    w.pos  = t_pos'($urandom);
                end else begin
                    w.kind = KIND_EVAL;
                    pick = $urandom_range(0, 9);
                    if (n == 0 || pick >= 6) begin
                        w.pos = t_pos'($urandom);
                    end else if (pick == 0) begin
                        w.pos = 16'h0000;
                    end else if (pick == 1) begin
                        w.pos = 16'hFFFF;
                    end else if (pick <= 3) begin
                        w.pos = grad_pos[$urandom_range(0, n - 1)];
                    end else if (pick == 4) begin
                        w.pos = grad_pos[$urandom_range(0, n - 1)] + 16'd1;
                    end else begin
                        w.pos = grad_pos[$urandom_range(0, n - 1)] - 16'd1;
                    end
                end
                pace_sender();
                send_word(w, 1'b0, '0);
            end
        end

        wait_idle();
        $display("covered %0d stop writes and %0d evaluates over %0d stop-count settings",
                 stop_writes, evaluates, count_settings);
        $display("%0d colors compared, %0d mismatches", colors_checked, mismatches);
        if (mismatches == 0 && expected_colors.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

[color_gradient_interpolator.f]
+incdir+rtl
rtl/cgi_pkg.sv
rtl/cgi_in_if.sv
rtl/cgi_out_if.sv
rtl/cgi_ram.sv
rtl/cgi_div.sv
rtl/cgi_blend.sv
rtl/color_gradient_interpolator.sv
sim/color_gradient_interpolator_test.sv
